FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and codes for the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam logic [2:0] MODE_START_ONESHOT = 3'd0;
   localparam logic [2:0] MODE_START_RELOAD  = 3'd1;
   localparam logic [2:0] MODE_STOP          = 3'd2;
   localparam logic [2:0] MODE_QUERY         = 3'd3;
   localparam logic [2:0] MODE_COUNT         = 3'd4;
   localparam logic [2:0] MODE_TICK          = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request transaction
      logic scan_rst; // restart read/write pointers
      logic scan_inc; // step read pointer
      logic cmd_step; // evaluate a command slot
      logic tick_step;// evaluate a tick slot
      logic finish;   // apply command result
      logic out_event;// load event into output register
      logic out_reply;// load reply into output register
   } stt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] mode;
      logic       scan_done; // read pointer reached count
      logic       hit;       // matched key seen
      logic       ev_pend;   // tick slot has an event to emit
   } stt_stat_type;

endpackage

FILE: sv/software_timer_table_top.sv
// ----------------------------------------------------------------------------
// software_timer_table_top
// software timer table with insertion-ordered slots and tick processing
// ----------------------------------------------------------------------------
// commands compare one slot per cycle until a match or the end of the table
// ticks decrement and compact each slot via TICK then EMIT; events wait out rsp_stall
// one transaction in flight; the next request waits for the reply to be loaded
// synchronous reset empties the table, clears the clock, tick_amount returns to 1
module software_timer_table_top #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_event_flag,
   input  logic [15:0] req_timeout,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_value,
   output logic [7:0]  rsp_event_task,
   output logic [15:0] rsp_event_bits,
   output logic [31:0] rsp_system_clock,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_tick_amount
);
   import stt_pkg::*;

   stt_cmd_type  cmd;
   stt_stat_type stat;
   logic [7:0]   tick_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) tick_ff <= 8'd1;
      else if (csr_valid) tick_ff <= csr_tick_amount;
   end

   stt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .stat
   );

   stt_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
      .clock, .reset, .req_mode, .req_task_id, .req_event_flag, .req_timeout,
      .csr_tick_amount(tick_ff), .cmd, .stat,
      .rsp_kind, .rsp_status, .rsp_value, .rsp_event_task, .rsp_event_bits,
      .rsp_system_clock, .rsp_last
   );
endmodule

FILE: sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// sequencer for commands and ticks
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stt_pkg::stt_cmd_type cmd,
   input  stt_pkg::stt_stat_type stat
);
   import stt_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_TICK = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       outbusy;

   assign outbusy   = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_rst = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // the mode is known here; ticks take their own loop
            if (stat.mode == MODE_TICK) begin
               state_in = ST_TICK;
            end else if (stat.scan_done || stat.hit) begin
               state_in = ST_DONE;
            end else begin
               cmd.cmd_step = 1'b1;
               cmd.scan_inc = 1'b1;
            end
         end
         ST_TICK: begin
            if (stat.scan_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.tick_step = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!stat.ev_pend) begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_TICK;
            end else if (!outbusy) begin
               cmd.out_event = 1'b1;
               rsp_valid_in  = 1'b1;
               cmd.scan_inc  = 1'b1;
               state_in      = ST_TICK;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!outbusy) begin
               cmd.out_reply = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_one: assert property (@(posedge clock) disable iff (reset)
      cmd.out_event |-> !cmd.out_reply)
      else $error("event and reply loaded together");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> req_stall)
      else $error("accepting during tick");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("transaction dropped under stall");
endmodule

FILE: sv/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// timer table storage, scan pointers and output register
// ----------------------------------------------------------------------------
module stt_dp #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_mode,
   input  logic [7:0]            req_task_id,
   input  logic [15:0]           req_event_flag,
   input  logic [15:0]           req_timeout,
   input  logic [7:0]            csr_tick_amount,
   input  stt_pkg::stt_cmd_type  cmd,
   output stt_pkg::stt_stat_type stat,
   output logic                  rsp_kind,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_value,
   output logic [7:0]            rsp_event_task,
   output logic [15:0]           rsp_event_bits,
   output logic [31:0]           rsp_system_clock,
   output logic                  rsp_last
);
   import stt_pkg::*;

   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   logic [7:0]  task_ff   [TIMER_SLOTS];
   logic [15:0] event_ff  [TIMER_SLOTS];
   logic [15:0] remain_ff [TIMER_SLOTS];
   logic [15:0] reload_ff [TIMER_SLOTS];

   logic [CW-1:0] count_ff, rd_ff, wr_ff;
   logic [31:0]   clock_ff;
   logic [2:0]    mode_ff;
   logic [7:0]    task_id_ff;
   logic [15:0]   flag_ff, tmo_ff;
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          pend_ff;
   logic [7:0]    pend_task_ff;
   logic [15:0]   pend_bits_ff;
   logic [1:0]    rep_status_ff, rep_status_in;
   logic [15:0]   rep_value_ff, rep_value_in;

   logic          ob_kind_ff;
   logic [1:0]    ob_status_ff;
   logic [15:0]   ob_value_ff;
   logic [7:0]    ob_task_ff;
   logic [15:0]   ob_bits_ff;
   logic [31:0]   ob_clock_ff;
   logic          ob_last_ff;

   logic [IW-1:0] ri, wi, ci;
   logic [15:0]   rem, dec;
   logic          refire, keep;

   assign ri   = rd_ff[IW-1:0];
   assign wi   = wr_ff[IW-1:0];
   assign ci   = count_ff[IW-1:0];
   assign dec  = {8'd0, csr_tick_amount};

   always_comb begin
      rem    = (remain_ff[ri] <= dec) ? 16'd0 : remain_ff[ri] - dec;
      refire = (rem == 16'd0) && (reload_ff[ri] != 16'd0) && (event_ff[ri] != 16'd0);
      if (refire) rem = reload_ff[ri];
      keep   = (rem != 16'd0) && (event_ff[ri] != 16'd0);
   end

   // reply fields for the command in hand
   always_comb begin
      rep_status_in = STATUS_OK;
      rep_value_in  = '0;
      unique case (mode_ff)
         MODE_START_ONESHOT, MODE_START_RELOAD: begin
            if (!hit_ff && count_ff >= CW'(TIMER_SLOTS)) rep_status_in = STATUS_NO_SLOT;
         end
         MODE_STOP: begin
            if (!hit_ff) rep_status_in = STATUS_NOT_FOUND;
         end
         MODE_QUERY: begin
            if (hit_ff) rep_value_in = remain_ff[hit_idx_ff];
            else rep_status_in = STATUS_NOT_FOUND;
         end
         MODE_COUNT: rep_value_in = 16'(count_ff);
         default: ;
      endcase
   end

   assign stat.mode      = mode_ff;
   assign stat.scan_done = (rd_ff >= count_ff);
   assign stat.hit       = hit_ff;
   assign stat.ev_pend   = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clock_ff <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         rd_ff    <= '0;
         wr_ff    <= '0;
      end else begin
         if (cmd.load) begin
            mode_ff    <= req_mode;
            task_id_ff <= req_task_id;
            flag_ff    <= req_event_flag;
            tmo_ff     <= req_timeout;
            if (req_mode == MODE_TICK) clock_ff <= clock_ff + {24'd0, csr_tick_amount};
         end
         if (cmd.scan_rst) begin
            rd_ff  <= '0;
            wr_ff  <= '0;
            hit_ff <= 1'b0;
         end
         if (cmd.scan_inc) rd_ff <= rd_ff + 1'b1;
         if (cmd.cmd_step && task_ff[ri] == task_id_ff && event_ff[ri] == flag_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= ri;
         end
         if (cmd.tick_step) begin
            pend_task_ff <= task_ff[ri];
            pend_bits_ff <= event_ff[ri];
            pend_ff      <= refire || (rem == 16'd0);
            if (keep) begin
               task_ff[wi]   <= task_ff[ri];
               event_ff[wi]  <= event_ff[ri];
               remain_ff[wi] <= rem;
               reload_ff[wi] <= reload_ff[ri];
               wr_ff         <= wr_ff + 1'b1;
            end
         end
         if (cmd.out_event) pend_ff <= 1'b0;
         if (cmd.finish) begin
            rep_status_ff <= rep_status_in;
            rep_value_ff  <= rep_value_in;
            unique case (mode_ff)
               MODE_START_ONESHOT, MODE_START_RELOAD: begin
                  if (hit_ff) begin
                     remain_ff[hit_idx_ff] <= tmo_ff;
                     if (mode_ff == MODE_START_RELOAD) reload_ff[hit_idx_ff] <= tmo_ff;
                  end else if (count_ff < CW'(TIMER_SLOTS)) begin
                     task_ff[ci]   <= task_id_ff;
                     event_ff[ci]  <= flag_ff;
                     remain_ff[ci] <= tmo_ff;
                     reload_ff[ci] <= (mode_ff == MODE_START_RELOAD) ? tmo_ff : 16'd0;
                     count_ff      <= count_ff + 1'b1;
                  end
               end
               MODE_STOP: begin
                  if (hit_ff) event_ff[hit_idx_ff] <= '0;
               end
               MODE_TICK: count_ff <= wr_ff;
               default: ;
            endcase
         end
      end
   end

   // output register: out_event loads an event, finish stages the reply, out_reply releases it
   always_ff @(posedge clock) begin
      if (cmd.out_event) begin
         ob_kind_ff   <= KIND_EVENT;
         ob_status_ff <= STATUS_OK;
         ob_value_ff  <= '0;
         ob_task_ff   <= pend_task_ff;
         ob_bits_ff   <= pend_bits_ff;
         ob_clock_ff  <= clock_ff;
         ob_last_ff   <= 1'b0;
      end
      if (cmd.out_reply) begin
         ob_kind_ff   <= KIND_REPLY;
         ob_status_ff <= rep_status_ff;
         ob_value_ff  <= rep_value_ff;
         ob_task_ff   <= '0;
         ob_bits_ff   <= '0;
         ob_clock_ff  <= clock_ff;
         ob_last_ff   <= 1'b1;
      end
   end

   assign rsp_kind         = ob_kind_ff;
   assign rsp_status       = ob_status_ff;
   assign rsp_value        = ob_value_ff;
   assign rsp_event_task   = ob_task_ff;
   assign rsp_event_bits   = ob_bits_ff;
   assign rsp_system_clock = ob_clock_ff;
   assign rsp_last         = ob_last_ff;

   a_wr_behind: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wr_ff} <= {1'b0, rd_ff} + 1'b1)
      else $error("compaction overtook scan");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TIMER_SLOTS))
      else $error("count overflow");
   a_evt_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.out_event |-> pend_ff)
      else $error("event without pending slot");
endmodule
